>>> rtl/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int G      = 8;
    localparam int DW     = 2 * CW + 1;
    localparam int SK     = (DW + 2 * G + 1) / 2;
    localparam int SX     = 2 * SK;
    localparam int RW     = SK + 2;
    localparam int MW     = SK + 1;
    localparam int DENW   = CW + 1;
    localparam int RMW    = DENW + 1;
    localparam int QB     = CW;
    localparam int NW     = MW + FB - G + 1;
    localparam int TOLA_W = CW - 1;
    localparam int TOLD_W = 2 * CW - 1;
    localparam int CFG_W  = TOLD_W;
    localparam int CFG_IW = 1;

    localparam logic [CFG_IW-1:0] CFG_COEFF_TOL = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_DISC_TOL  = 1'b1;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ANY  = 2'd3;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ONE,
        MODE_TWO
    } t_mode;

    typedef struct packed {
        logic signed [CW-1:0] coef_quad;
        logic signed [CW-1:0] coef_lin;
        logic signed [CW-1:0] coef_const;
    } t_in;

    typedef struct packed {
        logic [1:0]           root_count;
        logic signed [CW-1:0] root_first;
        logic signed [CW-1:0] root_second;
        logic                 root_overflow;
    } t_out;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [SK-1:0] root;
        logic [SX-1:0] x;
    } t_sq;

    typedef struct packed {
        logic [RMW-1:0]  rem;
        logic [QB-1:0]   nq;
        logic [DENW-1:0] den;
    } t_dv;

    typedef struct packed {
        t_mode           mode;
        logic [1:0]      count;
        logic            an;
        logic            bs;
        logic [CW-1:0]   am;
        logic [CW-1:0]   bm;
        logic            neg1;
        logic [NW-1:0]   num1;
        logic [DENW-1:0] den;
    } t_side;

    typedef struct packed {
        logic [1:0] count;
        logic       rep1;
        logic       rep2;
        logic       neg1;
        logic       neg2;
        logic       big1;
        logic       big2;
    } t_dside;

endpackage
`default_nettype wire

>>> rtl/qrs_sqrt_cell.sv
`default_nettype none
module qrs_sqrt_cell (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire qrs_pkg::t_sq i_sq,
    output qrs_pkg::t_sq     o_sq
);
    import qrs_pkg::*;

    t_sq             r_sq;
    logic [RW-1:0]   w_rem2;
    logic [RW-1:0]   w_trial;
    logic            w_take;

    always_comb begin
        w_rem2  = {i_sq.rem[RW-3:0], i_sq.x[SX-1 -: 2]};
        w_trial = {i_sq.root, 2'b01};
        w_take  = (w_rem2 >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq.rem  <= w_take ? (w_rem2 - w_trial) : w_rem2;
            r_sq.root <= {i_sq.root[SK-2:0], w_take};
            r_sq.x    <= {i_sq.x[SX-3:0], 2'b00};
        end
    end

    assign o_sq = r_sq;
endmodule
`default_nettype wire

>>> rtl/qrs_div_cell.sv
`default_nettype none
module qrs_div_cell (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire qrs_pkg::t_dv i_dv,
    output qrs_pkg::t_dv      o_dv
);
    import qrs_pkg::*;

    t_dv            r_dv;
    logic [RMW-1:0] w_rem2;
    logic [RMW-1:0] w_den;
    logic           w_ge;

    always_comb begin
        w_rem2 = {i_dv.rem[DENW-1:0], i_dv.nq[QB-1]};
        w_den  = {1'b0, i_dv.den};
        w_ge   = (w_rem2 >= w_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv.rem <= w_ge ? (w_rem2 - w_den) : w_rem2;
            r_dv.nq  <= {i_dv.nq[QB-2:0], w_ge};
            r_dv.den <= i_dv.den;
        end
    end

    assign o_dv = r_dv;
endmodule
`default_nettype wire

>>> rtl/quadratic_root_solver.sv
`default_nettype none
// Quadratic root solver: takes a, b, c in signed Q16.16 and returns the count and the real
// roots of a*x*x+b*x+c=0, rounded to nearest and saturated with an overflow flag. It accepts
// one transaction per clock while the output is not stalled, and passes each one through
// registers for decode, multiply, discriminant and classification, a row of 41 square-root cells
// (one root bit each), registers forming the numerators, two rows of 32 divider cells (one quotient bit
// each) and the output register. A stall on the output freezes the whole row of cells.
module quadratic_root_solver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire qrs_pkg::t_in                 i_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output qrs_pkg::t_out                     o_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [qrs_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [qrs_pkg::CFG_W-1:0]    i_cfg_data
);
    import qrs_pkg::*;

    logic              r_out_vld;
    t_out              r_out;
    logic              w_en;
    logic [TOLA_W-1:0] r_coeff_tol;
    logic [TOLD_W-1:0] r_disc_tol;

    assign o_stall = r_out_vld && i_stall;
    assign w_en    = !(r_out_vld && i_stall);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_tol <= TOLA_W'(1);
            r_disc_tol  <= TOLD_W'(4295);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEFF_TOL: r_coeff_tol <= i_cfg_data[TOLA_W-1:0];
                CFG_DISC_TOL:  r_disc_tol  <= i_cfg_data[TOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // decode
    logic          r_a_vld, r_a_an, r_a_bn, r_a_cn;
    logic [CW-1:0] r_a_am, r_a_bm, r_a_cm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_an <= i_data.coef_quad[CW-1];
            r_a_bn <= i_data.coef_lin[CW-1];
            r_a_cn <= i_data.coef_const[CW-1];
            r_a_am <= i_data.coef_quad[CW-1] ? -i_data.coef_quad : i_data.coef_quad;
            r_a_bm <= i_data.coef_lin[CW-1] ? -i_data.coef_lin : i_data.coef_lin;
            r_a_cm <= i_data.coef_const[CW-1] ? -i_data.coef_const : i_data.coef_const;
        end
    end

    // products
    logic            r_b_vld, r_b_an, r_b_bn, r_b_cn;
    logic [CW-1:0]   r_b_am, r_b_bm, r_b_cm;
    logic [2*CW-1:0] r_b_bb, r_b_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_an <= r_a_an;
            r_b_bn <= r_a_bn;
            r_b_cn <= r_a_cn;
            r_b_am <= r_a_am;
            r_b_bm <= r_a_bm;
            r_b_cm <= r_a_cm;
            r_b_bb <= r_a_bm * r_a_bm;
            r_b_ac <= r_a_am * r_a_cm;
        end
    end

    // discriminant
    logic          r_c_vld, r_c_an, r_c_bn, r_c_cn, r_c_dn;
    logic [CW-1:0] r_c_am, r_c_bm, r_c_cm;
    logic [DW-1:0] r_c_dm;
    logic [DW-1:0] w_bb, w_ac4, n_c_dm;
    logic          n_c_dn;

    always_comb begin
        w_bb  = {1'b0, r_b_bb};
        w_ac4 = {r_b_ac[2*CW-2:0], 2'b00};
        if (r_b_an != r_b_cn) begin
            n_c_dm = w_bb + w_ac4;
            n_c_dn = 1'b0;
        end else if (w_bb >= w_ac4) begin
            n_c_dm = w_bb - w_ac4;
            n_c_dn = 1'b0;
        end else begin
            n_c_dm = w_ac4 - w_bb;
            n_c_dn = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_an <= r_b_an;
            r_c_bn <= r_b_bn;
            r_c_cn <= r_b_cn;
            r_c_am <= r_b_am;
            r_c_bm <= r_b_bm;
            r_c_cm <= r_b_cm;
            r_c_dm <= n_c_dm;
            r_c_dn <= n_c_dn;
        end
    end

    // classification
    logic  r_k_vld;
    t_side r_k_side, n_k_side;
    t_sq   r_k_sq;
    logic  w_lin, w_dsmall;

    always_comb begin
        w_lin    = (r_c_am == '0) || (r_c_am < {1'b0, r_coeff_tol});
        w_dsmall = (r_c_dm < {{(DW-TOLD_W){1'b0}}, r_disc_tol});
        n_k_side.an   = r_c_an;
        n_k_side.bs   = !r_c_bn && (r_c_bm != '0);
        n_k_side.am   = r_c_am;
        n_k_side.bm   = r_c_bm;
        n_k_side.neg1 = 1'b0;
        n_k_side.num1 = '0;
        n_k_side.den  = DENW'(r_c_am) << 1;
        if (w_lin) begin
            n_k_side.den = DENW'(r_c_bm);
            if (r_c_bm == '0) begin
                n_k_side.mode  = MODE_NONE;
                n_k_side.count = (r_c_cm == '0) ? CNT_ANY : CNT_NONE;
            end else begin
                n_k_side.mode  = MODE_ONE;
                n_k_side.count = CNT_ONE;
                n_k_side.neg1  = (r_c_cm != '0) && (r_c_cn == r_c_bn);
                n_k_side.num1  = (NW'(r_c_cm) << FB) + NW'(r_c_bm >> 1);
            end
        end else if (w_dsmall) begin
            n_k_side.mode  = MODE_ONE;
            n_k_side.count = CNT_ONE;
            n_k_side.neg1  = (r_c_bm != '0) && (r_c_bn == r_c_an);
            n_k_side.num1  = (NW'(r_c_bm) << FB) + NW'(r_c_am);
        end else if (r_c_dn) begin
            n_k_side.mode  = MODE_NONE;
            n_k_side.count = CNT_NONE;
        end else begin
            n_k_side.mode  = MODE_TWO;
            n_k_side.count = CNT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (w_en) begin
            r_k_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_side    <= n_k_side;
            r_k_sq.rem  <= '0;
            r_k_sq.root <= '0;
            r_k_sq.x    <= SX'(r_c_dm) << (2 * G);
        end
    end

    // square root row
    t_sq     w_sq [SK+1];
    t_side   r_sl [SK];
    logic [SK-1:0] r_slv;

    assign w_sq[0] = r_k_sq;

    for (genvar k = 0; k < SK; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sq  (w_sq[k]),
            .o_sq  (w_sq[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slv <= '0;
        end else if (w_en) begin
            r_slv <= {r_slv[SK-2:0], r_k_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sl[0] <= r_k_side;
            for (int i = 1; i < SK; i++) begin
                r_sl[i] <= r_sl[i-1];
            end
        end
    end

    // signed sums of b and the root
    t_side         w_s;
    logic [MW-1:0] w_bp, w_sr, n_m1, n_m2;
    logic          n_n1, n_n2;
    logic          r_p_vld, r_p_neg1, r_p_neg2;
    logic [MW-1:0] r_p_m1, r_p_m2;
    t_side         r_p_side;

    always_comb begin
        w_s  = r_sl[SK-1];
        w_bp = MW'(w_s.bm) << G;
        w_sr = MW'(w_sq[SK].root);
        if (w_s.bs) begin
            n_m1 = w_bp + w_sr;
            n_n1 = 1'b1;
        end else if (w_bp >= w_sr) begin
            n_m1 = w_bp - w_sr;
            n_n1 = 1'b0;
        end else begin
            n_m1 = w_sr - w_bp;
            n_n1 = 1'b1;
        end
        if (!w_s.bs) begin
            n_m2 = w_bp + w_sr;
            n_n2 = 1'b0;
        end else if (w_bp >= w_sr) begin
            n_m2 = w_bp - w_sr;
            n_n2 = 1'b1;
        end else begin
            n_m2 = w_sr - w_bp;
            n_n2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_slv[SK-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_m1   <= n_m1;
            r_p_m2   <= n_m2;
            r_p_neg1 <= (n_m1 != '0) && (n_n1 != w_s.an);
            r_p_neg2 <= (n_m2 != '0) && (n_n2 != w_s.an);
            r_p_side <= w_s;
        end
    end

    // numerators with rounding
    logic            r_q_vld, r_q_nega, r_q_negb;
    logic [NW-1:0]   r_q_numa, r_q_numb;
    logic [DENW-1:0] r_q_den;
    t_dside          r_q_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (w_en) begin
            r_q_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_p_side.mode == MODE_TWO) begin
                r_q_numa <= (NW'(r_p_m1) << (FB - G)) + NW'(r_p_side.am);
                r_q_nega <= r_p_neg1;
            end else begin
                r_q_numa <= r_p_side.num1;
                r_q_nega <= r_p_side.neg1;
            end
            r_q_numb      <= (NW'(r_p_m2) << (FB - G)) + NW'(r_p_side.am);
            r_q_negb      <= r_p_neg2;
            r_q_den       <= r_p_side.den;
            r_q_ds.count  <= r_p_side.count;
            r_q_ds.rep1   <= (r_p_side.mode == MODE_ONE) || (r_p_side.mode == MODE_TWO);
            r_q_ds.rep2   <= (r_p_side.mode == MODE_TWO);
            r_q_ds.neg1   <= 1'b0;
            r_q_ds.neg2   <= 1'b0;
            r_q_ds.big1   <= 1'b0;
            r_q_ds.big2   <= 1'b0;
        end
    end

    // divider entry: quotients of 2^32 or more saturate at once
    logic   r_e_vld;
    t_dv    r_e_da, r_e_db;
    t_dside r_e_ds;
    logic   w_biga, w_bigb;

    always_comb begin
        w_biga = DENW'(r_q_numa[NW-1:QB]) >= r_q_den;
        w_bigb = DENW'(r_q_numb[NW-1:QB]) >= r_q_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_da.rem  <= w_biga ? '0 : RMW'(r_q_numa[NW-1:QB]);
            r_e_da.nq   <= r_q_numa[QB-1:0];
            r_e_da.den  <= r_q_den;
            r_e_db.rem  <= w_bigb ? '0 : RMW'(r_q_numb[NW-1:QB]);
            r_e_db.nq   <= r_q_numb[QB-1:0];
            r_e_db.den  <= r_q_den;
            r_e_ds.count <= r_q_ds.count;
            r_e_ds.rep1  <= r_q_ds.rep1;
            r_e_ds.rep2  <= r_q_ds.rep2;
            r_e_ds.neg1  <= r_q_nega;
            r_e_ds.neg2  <= r_q_negb;
            r_e_ds.big1  <= w_biga;
            r_e_ds.big2  <= w_bigb;
        end
    end

    // divider rows
    t_dv           w_da [QB+1];
    t_dv           w_db [QB+1];
    t_dside        r_dl [QB];
    logic [QB-1:0] r_dlv;

    assign w_da[0] = r_e_da;
    assign w_db[0] = r_e_db;

    for (genvar k = 0; k < QB; k++) begin : g_div
        qrs_div_cell u_cell_a (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_dv  (w_da[k]),
            .o_dv  (w_da[k+1])
        );
        qrs_div_cell u_cell_b (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_dv  (w_db[k]),
            .o_dv  (w_db[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlv <= '0;
        end else if (w_en) begin
            r_dlv <= {r_dlv[QB-2:0], r_e_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= r_e_ds;
            for (int i = 1; i < QB; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // saturation and output register
    t_dside        w_ds;
    logic [QB-1:0] w_lim1, w_lim2, w_m1, w_m2, w_r1, w_r2;
    logic          w_sat1, w_sat2;
    t_out          n_out;

    always_comb begin
        w_ds   = r_dl[QB-1];
        w_lim1 = {1'b1, {(QB-1){1'b0}}} - QB'(!w_ds.neg1);
        w_lim2 = {1'b1, {(QB-1){1'b0}}} - QB'(!w_ds.neg2);
        w_sat1 = w_ds.big1 || (w_da[QB].nq > w_lim1);
        w_sat2 = w_ds.big2 || (w_db[QB].nq > w_lim2);
        w_m1   = w_sat1 ? w_lim1 : w_da[QB].nq;
        w_m2   = w_sat2 ? w_lim2 : w_db[QB].nq;
        w_r1   = w_ds.rep1 ? (w_ds.neg1 ? -w_m1 : w_m1) : '0;
        w_r2   = w_ds.rep2 ? (w_ds.neg2 ? -w_m2 : w_m2) : '0;
        n_out.root_count    = w_ds.count;
        n_out.root_first    = $signed(w_r1);
        n_out.root_second   = $signed(w_r2);
        n_out.root_overflow = (w_ds.rep1 && w_sat1) || (w_ds.rep2 && w_sat2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dlv[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
    import qrs_pkg::*;

    typedef logic [127:0] t_wide;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;
        t_out                 exp;
    } t_row;

    localparam int LATENCY   = 81;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1930;
    localparam int N_PHASES  = 6;
    localparam logic signed [CW-1:0] ONE = 32'sd65536;
    localparam logic signed [CW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [CW-1:0] MINV = 32'sh80000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    t_in            i_data;
    logic           o_valid;
    logic           i_stall;
    t_out           o_data;
    logic           i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    logic [TOLA_W-1:0] tol_coef;
    logic [TOLD_W-1:0] tol_disc;

    t_out roots_due[$];
    int   n_fail;
    int   n_sent;
    int   idle_cycles;
    bit   calm;

    quadratic_root_solver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void sm_add(input bit s1, input t_wide m1, input bit s2,
                                   input t_wide m2, output bit so, output t_wide mo);
        if (s1 == s2) begin
            so = s1;
            mo = m1 + m2;
        end else if (m1 >= m2) begin
            so = s1;
            mo = m1 - m2;
        end else begin
            so = s2;
            mo = m2 - m1;
        end
        if (mo == 0) so = 1'b0;
    endfunction

    function automatic t_wide isqrt(input t_wide x);
        t_wide res;
        t_wide t;
        res = 0;
        for (int k = 63; k >= 0; k--) begin
            t = res | (t_wide'(1) << k);
            if (t * t <= x) res = t;
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] round_root(input bit neg, input t_wide num,
                                                 input t_wide den, inout bit ovf);
        t_wide lim;
        t_wide q;
        logic [CW-1:0] m;
        lim = neg ? (t_wide'(1) << 31) : (t_wide'(1) << 31) - 1;
        q = (num + (den >> 1)) / den;
        if (q > lim) begin
            m = lim[CW-1:0];
            ovf = 1'b1;
        end else begin
            m = q[CW-1:0];
        end
        return neg ? -m : m;
    endfunction

    function automatic t_out solve_roots(input t_in x);
        t_out  r;
        bit    an, bn, cn, dn, n1, n2, ovf;
        t_wide am, bm, cm, dm, den, s, bpart, m1, m2;
        an = x.coef_quad[CW-1];
        bn = x.coef_lin[CW-1];
        cn = x.coef_const[CW-1];
        am = an ? t_wide'(-x.coef_quad) & 64'hffffffff : t_wide'(x.coef_quad);
        bm = bn ? t_wide'(-x.coef_lin) & 64'hffffffff : t_wide'(x.coef_lin);
        cm = cn ? t_wide'(-x.coef_const) & 64'hffffffff : t_wide'(x.coef_const);
        if (am == 0) an = 1'b0;
        if (bm == 0) bn = 1'b0;
        if (cm == 0) cn = 1'b0;
        r = '0;
        ovf = 1'b0;
        sm_add(1'b0, bm * bm, an == cn, (am * cm) << 2, dn, dm);
        if (am == 0 || am < t_wide'(tol_coef)) begin
            if (bm == 0) begin
                r.root_count = (cm == 0) ? CNT_ANY : CNT_NONE;
            end else begin
                r.root_count = CNT_ONE;
                r.root_first = round_root(cm != 0 && cn == bn, cm << FB, bm, ovf);
            end
        end else if (dm < t_wide'(tol_disc)) begin
            r.root_count = CNT_ONE;
            r.root_first = round_root(bm != 0 && bn == an, bm << FB, am << 1, ovf);
        end else if (dn) begin
            r.root_count = CNT_NONE;
        end else begin
            r.root_count = CNT_TWO;
            den = am << 1;
            s = isqrt(dm << (2 * G));
            bpart = bm << G;
            sm_add(!bn && bm != 0, bpart, 1'b1, s, n1, m1);
            sm_add(!bn && bm != 0, bpart, 1'b0, s, n2, m2);
            r.root_first = round_root(m1 != 0 && n1 != an, m1 << (FB - G), den, ovf);
            r.root_second = round_root(m2 != 0 && n2 != an, m2 << (FB - G), den, ovf);
        end
        r.root_overflow = ovf;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] pick_edge();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return MAXV;
            4: return MINV;
            default: return $urandom;
        endcase
    endfunction

    function automatic int sgn_rand(input int hi);
        int v;
        v = $urandom_range(1, hi);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic t_in make_coefs();
        t_in x;
        int  k, m, p, q;
        x.coef_quad = $urandom;
        x.coef_lin = $urandom;
        x.coef_const = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3: begin
                x.coef_quad = $signed(x.coef_quad) >>> $urandom_range(8, 20);
                x.coef_lin = $signed(x.coef_lin) >>> $urandom_range(8, 20);
                x.coef_const = $signed(x.coef_const) >>> $urandom_range(8, 20);
            end
            4: x.coef_quad = $urandom_range(0, 8) - 4;
            5: begin
                k = sgn_rand(1024);
                m = sgn_rand(1024);
                x.coef_quad = k;
                x.coef_lin = 2 * k * m;
                x.coef_const = k * m * m;
            end
            6, 7: begin
                k = sgn_rand(256);
                p = sgn_rand(1024);
                q = sgn_rand(1024);
                x.coef_quad = k;
                x.coef_lin = -k * (p + q);
                x.coef_const = k * p * q;
            end
            8: begin
                x.coef_quad = pick_edge();
                x.coef_lin = pick_edge();
                x.coef_const = pick_edge();
            end
            default: begin
                x.coef_quad = 0;
                if ($urandom_range(0, 3) == 0) x.coef_lin = 0;
            end
        endcase
        return x;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send(input t_in x, input bit typed, input t_out exp);
        i_valid <= 1'b1;
        i_data <= x;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        roots_due.push_back(typed ? exp : solve_roots(x));
        n_sent++;
        repeat (gap_len()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (roots_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_COEFF_TOL) tol_coef = val[TOLA_W-1:0];
        else tol_disc = val[TOLD_W-1:0];
    endtask

    t_row rows[] = '{
        '{0, 0, 0, 1, '{CNT_ANY, 0, 0, 0}},
        '{0, 0, 5, 1, '{CNT_NONE, 0, 0, 0}},
        '{0, 0, MINV, 1, '{CNT_NONE, 0, 0, 0}},
        '{ONE, 0, ONE, 1, '{CNT_NONE, 0, 0, 0}},
        '{ONE, -2 * ONE, ONE, 1, '{CNT_ONE, ONE, 0, 0}},
        '{ONE, 0, -ONE, 1, '{CNT_TWO, -ONE, ONE, 0}},
        '{0, ONE, -2 * ONE, 1, '{CNT_ONE, 2 * ONE, 0, 0}},
        '{0, 1, MAXV, 1, '{CNT_ONE, MINV, 0, 1}},
        '{0, -1, MAXV, 1, '{CNT_ONE, MAXV, 0, 1}},
        '{MAXV, MAXV, MAXV, 0, '{default: 0}},
        '{MINV, MINV, MINV, 0, '{default: 0}},
        '{MINV, MAXV, MINV, 0, '{default: 0}},
        '{1, MINV, MAXV, 0, '{default: 0}},
        '{-1, 1, 0, 0, '{default: 0}},
        '{MAXV, 0, MINV, 0, '{default: 0}},
        '{1, 0, -1, 0, '{default: 0}},
        '{-1, MAXV, 1, 0, '{default: 0}},
        '{2, 4, 2, 0, '{default: 0}},
        '{ONE, ONE, MINV, 0, '{default: 0}},
        '{1, 1, MAXV, 0, '{default: 0}}
    };

    // transaction stream: directed rows, then random phases under changing tolerances
    initial begin
        t_in  x;
        t_out none;
        logic [CFG_W-1:0] ta, td;
        n_fail = 0;
        n_sent = 0;
        calm = 1'b0;
        none = '0;
        tol_coef = 1;
        tol_disc = 4295;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COEFF_TOL;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b0 | 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            x = '{rows[i].a, rows[i].b, rows[i].c};
            send(x, rows[i].typed, rows[i].exp);
        end
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            repeat (LATENCY + 10) @(posedge i_clk);
            case (ph)
                0: begin ta = CFG_W'(1); td = CFG_W'(4295); end
                1: begin ta = '0; td = '0; end
                2: begin ta = CFG_W'(31'h7fffffff); td = 63'h7fffffffffffffff; end
                3: begin
                    ta = CFG_W'($urandom_range(0, 1 << 18));
                    td = CFG_W'({$urandom, $urandom} >> 20);
                end
                4: begin ta = CFG_W'(ONE); td = CFG_W'(64'd1 << 40); end
                default: begin ta = CFG_W'(1); td = CFG_W'(4295); end
            endcase
            write_cfg(CFG_COEFF_TOL, ta);
            write_cfg(CFG_DISC_TOL, td);
            calm = ph[0];
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                if (ph == 3 && n == 150) drain();
                send(make_coefs(), 1'b0, none);
            end
        end
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_fail == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // receiver stalls, with one long hold once the pipe is busy
    initial begin
        bit held;
        held = 1'b0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && n_sent > 500) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            i_stall <= (gap_len() != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (roots_due.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_data);
                n_fail++;
            end else begin
                e = roots_due.pop_front();
                if (o_data.root_count !== e.root_count)
                    $display("%0t root_count exp %0d got %0d", $time, e.root_count,
                             o_data.root_count);
                if (o_data.root_first !== e.root_first)
                    $display("%0t root_first exp %h got %h", $time, e.root_first,
                             o_data.root_first);
                if (o_data.root_second !== e.root_second)
                    $display("%0t root_second exp %h got %h", $time, e.root_second,
                             o_data.root_second);
                if (o_data.root_overflow !== e.root_overflow)
                    $display("%0t root_overflow exp %b got %b", $time, e.root_overflow,
                             o_data.root_overflow);
                if (o_data !== e) n_fail++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
tb/tb_top.sv
